[rtl/core/pdhf_pkg.sv]
// Package: types and constants of the capture-header filter.
package pdhf_pkg;

    localparam int unsigned HEADER_LEN = 24;
    localparam int unsigned PREFIX_LEN = 4;
    localparam int unsigned OFFSET_W   = 5;
    localparam int unsigned BURST_MAX  = 4;
    localparam int unsigned COUNT_W    = 3;

    localparam logic [7:0] MAGIC_B0 = 8'hd4;
    localparam logic [7:0] MAGIC_B1 = 8'hc3;
    localparam logic [7:0] MAGIC_B2 = 8'hb2;
    localparam logic [7:0] MAGIC_B3 = 8'ha1;

    localparam logic OP_BLOCK_START = 1'b0;
    localparam logic OP_DATA        = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0]             count;
        logic [BURST_MAX-1:0][7:0]      bytes;
    } t_burst;

endpackage

[rtl/core/pdhf_filter.sv]
// Filter state: block offset, held prefix, header tracking and result burst.
module pdhf_filter
    import pdhf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_enable,
    output t_burst   o_burst
);

    localparam logic [OFFSET_W-1:0] PREFIX_LAST = OFFSET_W'(PREFIX_LEN - 1);
    localparam logic [OFFSET_W-1:0] PREFIX_DONE = OFFSET_W'(PREFIX_LEN);
    localparam logic [OFFSET_W-1:0] HDR_END     = OFFSET_W'(HEADER_LEN);

    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [2:0][7:0]     r_prefix, n_prefix;
    logic                r_seen, n_seen;
    logic                r_drop, n_drop;
    logic                magic;

    assign magic = (r_prefix[0] == MAGIC_B0) && (r_prefix[1] == MAGIC_B1) &&
                   (r_prefix[2] == MAGIC_B2) && (i_item.byte_in == MAGIC_B3);

    always_comb begin
        n_offset = r_offset;
        n_prefix = r_prefix;
        n_seen   = r_seen;
        n_drop   = r_drop;
        o_burst  = '0;
        if (i_accept) begin
            if (i_item.op == OP_BLOCK_START) begin
                n_offset = '0;
                n_drop   = 1'b0;
            end else if (i_enable) begin
                priority if (r_offset < PREFIX_LAST) begin
                    n_prefix[r_offset[1:0]] = i_item.byte_in;
                    n_offset = r_offset + 1'b1;
                end else if (r_offset == PREFIX_LAST) begin
                    n_offset = PREFIX_DONE;
                    if (magic && r_seen) begin
                        n_drop = 1'b1;
                    end else begin
                        o_burst.count    = COUNT_W'(BURST_MAX);
                        o_burst.bytes[0] = r_prefix[0];
                        o_burst.bytes[1] = r_prefix[1];
                        o_burst.bytes[2] = r_prefix[2];
                        o_burst.bytes[3] = i_item.byte_in;
                        n_seen = r_seen | magic;
                    end
                end else if (r_drop && (r_offset < HDR_END)) begin
                    n_offset = r_offset + 1'b1;
                end else begin
                    o_burst.count    = COUNT_W'(1);
                    o_burst.bytes[0] = i_item.byte_in;
                    if (r_offset < HDR_END) begin
                        n_offset = r_offset + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_prefix <= '0;
            r_seen   <= 1'b0;
            r_drop   <= 1'b0;
        end else begin
            r_offset <= n_offset;
            r_prefix <= n_prefix;
            r_seen   <= n_seen;
            r_drop   <= n_drop;
        end
    end

`ifndef SYNTHESIS
    a_offset_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= HDR_END)
        else $error("block offset beyond header length");
    a_drop_after_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_offset >= PREFIX_DONE) && r_seen)
        else $error("dropping header without a completed prefix");
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("header flag cleared outside reset");
`endif

endmodule

[rtl/core/pcap_duplicate_header_filter.sv]
// Top level: capture-header filter with configuration register and output burst buffer.
//
// Input channel (i_in_valid / o_in_stall / i_in): one item per transfer, either a
// block-start marker or a data byte. Output channel (o_out_valid / i_out_stall /
// o_out): one byte per transfer, last set on the final byte of an input item.
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_data): the enable bit; the port is
// always ready; the user, not the block, keeps it written while the block is idle.
// The first result of an item appears in the cycle after its transfer.
// Throughput: one item per cycle while each item yields at most one byte and
// the receiver does not stall. The fourth byte of a passed block yields four
// bytes, which leave the four-entry output shift register at one per cycle;
// o_in_stall stays high until the last of them transfers.
// Items that yield nothing are taken whenever the output buffer is free.
// Reset (synchronous, active low) clears enable, the block offset, the held
// prefix, the header flag and the output buffer.
// When the receiver stalls, the buffered byte holds on o_out and new input
// transfers wait until the last buffered byte is taken.
module pcap_duplicate_header_filter
    import pdhf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic                          r_enable;
    logic [COUNT_W-1:0]            r_left, n_left;
    logic [BURST_MAX-1:0][7:0]     r_bytes, n_bytes;
    logic                          in_xfer;
    logic                          out_xfer;
    logic                          room;
    t_burst                        burst;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_data;
        end
    end

    assign o_out_valid    = (r_left != '0);
    assign out_xfer       = o_out_valid && !i_out_stall;
    assign room           = (r_left == '0) || ((r_left == COUNT_W'(1)) && !i_out_stall);
    assign o_in_stall     = !room;
    assign in_xfer        = i_in_valid && room;
    assign o_out.byte_out = r_bytes[0];
    assign o_out.last     = (r_left == COUNT_W'(1));

    pdhf_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_item   (i_in),
        .i_enable (r_enable),
        .o_burst  (burst)
    );

    always_comb begin
        n_left  = r_left;
        n_bytes = r_bytes;
        if (in_xfer) begin
            n_left  = burst.count;
            n_bytes = burst.bytes;
        end else if (out_xfer) begin
            n_left  = r_left - 1'b1;
            n_bytes = {8'h00, r_bytes[BURST_MAX-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
        r_bytes <= n_bytes;
    end

`ifndef SYNTHESIS
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= COUNT_W'(BURST_MAX))
        else $error("output buffer count out of range");
    a_burst_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (burst.count != '0) |=> o_out_valid && (r_left == $past(burst.count)))
        else $error("accepted burst not loaded into output buffer");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > COUNT_W'(1)) |-> o_in_stall)
        else $error("input accepted while output buffer still busy");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !in_xfer |=> (r_left == $past(r_left) - 1'b1))
        else $error("output buffer count did not advance");
`endif

endmodule
